// ===== rtl/core/pcbs_pkg.sv =====
package pcbs_pkg;

  localparam int CONFIG_BYTES_DEF       = 256;
  localparam int BAR_WINDOW_OFFSETS_DEF = 256;
  localparam int BAR_COUNT_DEF          = 6;

  localparam logic [31:0] CFG_ID_WORD   = 32'h1234_10DE;
  localparam logic [31:0] CFG_MISS_WORD = 32'hFFFF_FFFF;

  localparam logic [3:0] CFG_MAX_BYTES = 4'd4;
  localparam logic [3:0] BAR_MAX_BYTES = 4'd8;

  typedef enum logic [2:0] {
    CMD_CFG_RD  = 3'd0,
    CMD_CFG_WR  = 3'd1,
    CMD_MMIO_RD = 3'd2,
    CMD_MMIO_WR = 3'd3,
    CMD_MEM_RD  = 3'd4,
    CMD_MEM_WR  = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_CFG_RD,
    KIND_CFG_WR,
    KIND_BAR_RD,
    KIND_BAR_WR
  } kind_t;

  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n) begin
        m[8*i +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// ===== rtl/core/pcbs_req_if.sv =====
interface pcbs_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [15:0] req_id;
  logic [7:0]  tag;
  logic [11:0] offset;
  logic [3:0]  size;
  logic [2:0]  bar_num;
  logic [63:0] write_data;

  modport source (
    output valid, command, req_id, tag, offset, size, bar_num, write_data,
    input  ready
  );

  modport sink (
    input  valid, command, req_id, tag, offset, size, bar_num, write_data,
    output ready
  );
endinterface

// ===== rtl/core/pcbs_cpl_if.sv =====
interface pcbs_cpl_if;
  logic        valid;
  logic        ready;
  logic [15:0] cpl_req_id;
  logic [7:0]  cpl_tag;
  logic [3:0]  cpl_len;
  logic [63:0] cpl_data;

  modport source (
    output valid, cpl_req_id, cpl_tag, cpl_len, cpl_data,
    input  ready
  );

  modport sink (
    input  valid, cpl_req_id, cpl_tag, cpl_len, cpl_data,
    output ready
  );
endinterface

// ===== rtl/core/pcbs_ram.sv =====
module pcbs_ram
  import pcbs_pkg::*;
#(
  parameter int WIDTH = 64,
  parameter int DEPTH = BAR_COUNT_DEF * BAR_WINDOW_OFFSETS_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/pcie_completer_config_and_bar_store_unit.sv =====
// completer for configuration and bar window requests
// req: one request per handshake (command, req_id, tag, offset, size,
//   bar_num, write_data); writes and unknown commands give no completion
// cpl: one completion per read request, echoing the requester id and tag
// a request is taken on a handshake; its store read is issued at acceptance,
//   the read-modify-write or completion build happens in stage two, and the
//   completion is registered in the completion register before it is valid
// one request is taken per cycle while stage two can move and no sweep runs,
//   set by the single read and write port of each store; a write followed at
//   once by a request to the same entry is served from a forwarding register
// after reset both stores are swept one entry a cycle, the configuration
//   store to its reset pattern and the bar store to zero; the sweep covers
//   max(CONFIG_BYTES/4, BAR_COUNT*BAR_WINDOW_OFFSETS) entries (1536 by default),
//   during which no request is accepted
// when the receiver stalls, the completion register holds; a further read
//   request waits in the second stage and input ready drops until it moves
module pcie_completer_config_and_bar_store_unit
  import pcbs_pkg::*;
#(
  parameter int CONFIG_BYTES       = CONFIG_BYTES_DEF,
  parameter int BAR_WINDOW_OFFSETS = BAR_WINDOW_OFFSETS_DEF,
  parameter int BAR_COUNT          = BAR_COUNT_DEF
) (
  input logic        clk,
  input logic        rst,
  pcbs_req_if.sink   req,
  pcbs_cpl_if.source cpl
);

  localparam int CFG_WORDS   = CONFIG_BYTES / 4;
  localparam int STORE_DEPTH = BAR_COUNT * BAR_WINDOW_OFFSETS;
  localparam int CAW         = $clog2(CFG_WORDS);
  localparam int SAW         = $clog2(STORE_DEPTH);
  localparam int CLR_LEN     = (CFG_WORDS > STORE_DEPTH) ? CFG_WORDS : STORE_DEPTH;
  localparam int CLW         = $clog2(CLR_LEN);

  // clearing sweep
  logic           clearing;
  logic [CLW-1:0] clr_cnt;

  // stage two
  logic           s2_valid;
  kind_t          s2_kind;
  logic           s2_hit;
  logic [15:0]    s2_rid;
  logic [7:0]     s2_tag;
  logic [3:0]     s2_nbytes;
  logic [CAW-1:0] s2_cidx;
  logic [SAW-1:0] s2_slot;
  logic [63:0]    s2_wdata;

  // forwarding of the last write to each store
  logic           cfg_fwd_valid;
  logic [CAW-1:0] cfg_fwd_addr;
  logic [31:0]    cfg_fwd_data;
  logic           bar_fwd_valid;
  logic [SAW-1:0] bar_fwd_addr;
  logic [63:0]    bar_fwd_data;

  // completion register
  logic        out_valid;
  logic [15:0] out_rid;
  logic [7:0]  out_tag;
  logic [3:0]  out_nbytes;
  logic [63:0] out_data;

  // decode
  kind_t          in_kind;
  logic           in_hit;
  logic [3:0]     in_nbytes;
  logic [CAW-1:0] in_cidx;
  logic [SAW-1:0] in_slot;
  logic [9:0]     in_widx;
  logic           cfg_hit;
  logic           bar_hit;

  logic accept;
  logic out_free;
  logic s2_read;
  logic s2_go;

  logic           cfg_we;
  logic [CAW-1:0] cfg_waddr;
  logic [31:0]    cfg_wdata;
  logic [31:0]    cfg_rdata;
  logic [31:0]    cfg_word;
  logic [31:0]    cfg_merged;
  logic           bar_we;
  logic [SAW-1:0] bar_waddr;
  logic [63:0]    bar_wdata;
  logic [63:0]    bar_rdata;
  logic [63:0]    bar_word;
  logic [63:0]    s2_result;

  assign in_widx = req.offset[11:2];
  assign cfg_hit = 32'({req.offset[11:2], 2'b00}) < 32'(CONFIG_BYTES);
  assign bar_hit = (32'(req.bar_num) < 32'(BAR_COUNT))
                && (32'(req.offset) < 32'(BAR_WINDOW_OFFSETS));
  assign in_cidx = (32'(in_widx) == 32'(CFG_WORDS)) ? '0 : in_widx[CAW-1:0];
  assign in_slot = SAW'(32'(req.bar_num) * 32'(BAR_WINDOW_OFFSETS) + 32'(req.offset));

  always_comb begin
    in_kind   = KIND_NONE;
    in_hit    = 1'b0;
    in_nbytes = '0;
    unique case (req.command) inside
      CMD_CFG_RD, CMD_CFG_WR: begin
        in_kind   = (req.command == CMD_CFG_RD) ? KIND_CFG_RD : KIND_CFG_WR;
        in_hit    = cfg_hit;
        in_nbytes = (req.size < CFG_MAX_BYTES) ? req.size : CFG_MAX_BYTES;
      end
      CMD_MMIO_RD, CMD_MEM_RD: begin
        in_kind   = KIND_BAR_RD;
        in_hit    = bar_hit;
        in_nbytes = (req.size < BAR_MAX_BYTES) ? req.size : BAR_MAX_BYTES;
      end
      CMD_MMIO_WR, CMD_MEM_WR: begin
        in_kind = KIND_BAR_WR;
        in_hit  = bar_hit;
      end
      default: begin
        in_kind = KIND_NONE;
      end
    endcase
  end

  assign out_free  = !out_valid || cpl.ready;
  assign s2_read   = (s2_kind == KIND_CFG_RD) || (s2_kind == KIND_BAR_RD);
  assign s2_go     = s2_valid && (!s2_read || out_free);
  assign req.ready = !clearing && (!s2_valid || s2_go);
  assign accept    = req.valid && req.ready;

  // read data with forwarding
  assign cfg_word = (cfg_fwd_valid && (cfg_fwd_addr == s2_cidx)) ? cfg_fwd_data : cfg_rdata;
  assign bar_word = (bar_fwd_valid && (bar_fwd_addr == s2_slot)) ? bar_fwd_data : bar_rdata;

  always_comb begin
    case (s2_nbytes)
      4'd1:    cfg_merged = {cfg_word[31:8], s2_wdata[7:0]};
      4'd2:    cfg_merged = {cfg_word[31:16], s2_wdata[15:0]};
      default: cfg_merged = s2_wdata[31:0];
    endcase
  end

  // s2_nbytes holds the clipped width for config writes too
  always_comb begin
    if (s2_kind == KIND_CFG_RD) begin
      s2_result = {32'd0, s2_hit ? cfg_word : CFG_MISS_WORD} & byte_mask(s2_nbytes);
    end else begin
      s2_result = (s2_hit ? bar_word : 64'd0) & byte_mask(s2_nbytes);
    end
  end

  always_comb begin
    if (clearing) begin
      cfg_we    = 32'(clr_cnt) < 32'(CFG_WORDS);
      cfg_waddr = clr_cnt[CAW-1:0];
      cfg_wdata = (clr_cnt == '0) ? CFG_ID_WORD : 32'd0;
      bar_we    = 32'(clr_cnt) < 32'(STORE_DEPTH);
      bar_waddr = clr_cnt[SAW-1:0];
      bar_wdata = 64'd0;
    end else begin
      cfg_we    = s2_go && s2_hit && (s2_kind == KIND_CFG_WR);
      cfg_waddr = s2_cidx;
      cfg_wdata = cfg_merged;
      bar_we    = s2_go && s2_hit && (s2_kind == KIND_BAR_WR);
      bar_waddr = s2_slot;
      bar_wdata = s2_wdata;
    end
  end

  pcbs_ram #(
    .WIDTH (32),
    .DEPTH (CFG_WORDS)
  ) u_cfg_ram (
    .clk   (clk),
    .we    (cfg_we),
    .waddr (cfg_waddr),
    .wdata (cfg_wdata),
    .re    (accept),
    .raddr (in_cidx),
    .rdata (cfg_rdata)
  );

  pcbs_ram #(
    .WIDTH (64),
    .DEPTH (STORE_DEPTH)
  ) u_bar_ram (
    .clk   (clk),
    .we    (bar_we),
    .waddr (bar_waddr),
    .wdata (bar_wdata),
    .re    (accept),
    .raddr (in_slot),
    .rdata (bar_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing      <= 1'b1;
      clr_cnt       <= '0;
      s2_valid      <= 1'b0;
      out_valid     <= 1'b0;
      cfg_fwd_valid <= 1'b0;
      bar_fwd_valid <= 1'b0;
    end else begin
      if (clearing) begin
        if (32'(clr_cnt) == 32'(CLR_LEN - 1)) begin
          clearing <= 1'b0;
        end
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (accept) begin
        s2_valid <= 1'b1;
      end else if (s2_go) begin
        s2_valid <= 1'b0;
      end
      if (s2_go && s2_read) begin
        out_valid <= 1'b1;
      end else if (cpl.ready) begin
        out_valid <= 1'b0;
      end
      if (!clearing && cfg_we) begin
        cfg_fwd_valid <= 1'b1;
      end
      if (!clearing && bar_we) begin
        bar_fwd_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_kind   <= in_kind;
      s2_hit    <= in_hit;
      s2_rid    <= req.req_id;
      s2_tag    <= req.tag;
      s2_nbytes <= (in_kind == KIND_CFG_WR)
                 ? ((req.size < CFG_MAX_BYTES) ? req.size : CFG_MAX_BYTES) : in_nbytes;
      s2_cidx   <= in_cidx;
      s2_slot   <= in_slot;
      s2_wdata  <= req.write_data;
    end
    if (!clearing && cfg_we) begin
      cfg_fwd_addr <= cfg_waddr;
      cfg_fwd_data <= cfg_wdata;
    end
    if (!clearing && bar_we) begin
      bar_fwd_addr <= bar_waddr;
      bar_fwd_data <= bar_wdata;
    end
    if (s2_go && s2_read) begin
      out_rid    <= s2_rid;
      out_tag    <= s2_tag;
      out_nbytes <= s2_nbytes;
      out_data   <= s2_result;
    end
  end

  assign cpl.valid      = out_valid;
  assign cpl.cpl_req_id = out_rid;
  assign cpl.cpl_tag    = out_tag;
  assign cpl.cpl_len    = out_nbytes;
  assign cpl.cpl_data   = out_data;

endmodule

// ===== test/pcie_completer_config_and_bar_store_unit_test.sv =====
`timescale 1ns / 1ps

module pcie_completer_config_and_bar_store_unit_test;
  import pcbs_pkg::*;

  localparam logic [2:0] CMD_RSVD_A = 3'd6;
  localparam logic [2:0] CMD_RSVD_B = 3'd7;
  localparam int RANDOM_REQS = 1700;
  localparam int CFG_WORDS = CONFIG_BYTES_DEF / 4;
  localparam int BAR_ENTRIES = BAR_COUNT_DEF * BAR_WINDOW_OFFSETS_DEF;

  typedef struct {
    logic [2:0]  command;
    logic [15:0] req_id;
    logic [7:0]  tag;
    logic [11:0] offset;
    logic [3:0]  size;
    logic [2:0]  bar_num;
    logic [63:0] write_data;
  } request_t;

  typedef struct {
    logic [15:0] req_id;
    logic [7:0]  tag;
    logic [3:0]  nbytes;
    logic [63:0] data;
  } completion_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pcbs_req_if req_if ();
  pcbs_cpl_if cpl_if ();

  pcie_completer_config_and_bar_store_unit i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .cpl (cpl_if)
  );

  request_t    req_plan[$];
  completion_t cpl_expected[$];
  logic [31:0] cfg_shadow[CFG_WORDS];
  logic [63:0] bar_shadow[BAR_ENTRIES];

  int mismatches = 0;
  int planned_reqs = 0;
  int directed_reqs = 0;
  int accepted_reqs = 0;
  int cpls_seen = 0;
  int req_quiet = 0;
  int cpl_quiet = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_pause(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      quiet = $urandom_range(30, 150);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] keep_low(logic [63:0] v, logic [3:0] n);
    if (n >= 4'd8) return v;
    return v & ((64'd1 << (8 * n)) - 64'd1);
  endfunction

  // updates the shadow stores, returns 1 when the request yields a completion
  function automatic bit apply_request(input request_t r, output completion_t c);
    logic [11:0] cfg_off;
    logic [3:0]  width;
    logic [31:0] word;
    logic [63:0] entry;
    int          idx;
    bit          in_window;
    c.req_id = r.req_id;
    c.tag = r.tag;
    c.nbytes = '0;
    c.data = '0;
    cfg_off = r.offset & ~12'h3;
    idx = int'(cfg_off >> 2);
    in_window = r.bar_num < BAR_COUNT_DEF && r.offset < BAR_WINDOW_OFFSETS_DEF;
    case (r.command)
      CMD_CFG_RD, CMD_CFG_WR: begin
        width = (r.size < CFG_MAX_BYTES) ? r.size : CFG_MAX_BYTES;
        if (r.command == CMD_CFG_RD) begin
          word = (cfg_off < CONFIG_BYTES_DEF) ? cfg_shadow[idx] : CFG_MISS_WORD;
          c.nbytes = width;
          c.data = keep_low({32'd0, word}, width);
          return 1'b1;
        end
        if (cfg_off < CONFIG_BYTES_DEF) begin
          if (width == 4'd2) cfg_shadow[idx][15:0] = r.write_data[15:0];
          else if (width == 4'd1) cfg_shadow[idx][7:0] = r.write_data[7:0];
          else cfg_shadow[idx] = r.write_data[31:0];
        end
        return 1'b0;
      end
      CMD_MMIO_RD, CMD_MEM_RD: begin
        entry = in_window ? bar_shadow[r.bar_num * BAR_WINDOW_OFFSETS_DEF + r.offset] : '0;
        c.nbytes = (r.size < BAR_MAX_BYTES) ? r.size : BAR_MAX_BYTES;
        c.data = keep_low(entry, c.nbytes);
        return 1'b1;
      end
      CMD_MMIO_WR, CMD_MEM_WR: begin
        if (in_window) bar_shadow[r.bar_num * BAR_WINDOW_OFFSETS_DEF + r.offset] = r.write_data;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void add_request(logic [2:0] command, logic [11:0] offset,
                                      logic [3:0] size, logic [2:0] bar_num,
                                      logic [63:0] write_data);
    request_t r;
    r.command = command;
    r.req_id = 16'($urandom);
    r.tag = 8'($urandom);
    r.offset = offset;
    r.size = size;
    r.bar_num = bar_num;
    r.write_data = write_data;
    req_plan.push_back(r);
  endfunction

  function automatic logic [11:0] pick_cfg_offset();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 12'($urandom_range(0, 31));
    if (r < 90) return 12'($urandom_range(0, CONFIG_BYTES_DEF - 1));
    return 12'($urandom);
  endfunction

  function automatic logic [11:0] pick_bar_offset();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 12'($urandom_range(0, 15));
    if (r < 85) return 12'($urandom_range(0, BAR_WINDOW_OFFSETS_DEF - 1));
    return 12'($urandom);
  endfunction

  function automatic logic [2:0] pick_bar();
    if ($urandom_range(0, 9) == 0) return 3'($urandom_range(BAR_COUNT_DEF, 7));
    return 3'($urandom_range(0, BAR_COUNT_DEF - 1));
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // request driver
  always @(posedge clk) begin : drive_req
    request_t    on_bus;
    completion_t c;
    int          gap_left;
    if (rst) begin
      req_if.valid <= 1'b0;
      gap_left = 0;
      for (int i = 0; i < CFG_WORDS; i++) cfg_shadow[i] = '0;
      for (int i = 0; i < BAR_ENTRIES; i++) bar_shadow[i] = '0;
      cfg_shadow[0] = CFG_ID_WORD;
    end else begin
      if (req_if.valid && req_if.ready) begin
        accepted_reqs++;
        if (apply_request(on_bus, c)) cpl_expected.push_back(c);
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (req_plan.size() > 0) begin
          on_bus = req_plan.pop_front();
          req_if.valid <= 1'b1;
          req_if.command <= on_bus.command;
          req_if.req_id <= on_bus.req_id;
          req_if.tag <= on_bus.tag;
          req_if.offset <= on_bus.offset;
          req_if.size <= on_bus.size;
          req_if.bar_num <= on_bus.bar_num;
          req_if.write_data <= on_bus.write_data;
          gap_left = pick_pause(req_quiet);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // completion monitor
  always @(posedge clk) begin : watch_cpl
    completion_t want;
    int          stall_left;
    if (rst) begin
      cpl_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (cpl_if.valid && cpl_if.ready) begin
        cpls_seen++;
        if (cpl_expected.size() == 0) begin
          $error("completion with none expected: tag %0h data %0h", cpl_if.cpl_tag,
                 cpl_if.cpl_data);
          mismatches++;
        end else begin
          want = cpl_expected.pop_front();
          check_field("cpl_req_id", want.req_id, cpl_if.cpl_req_id);
          check_field("cpl_tag", want.tag, cpl_if.cpl_tag);
          check_field("cpl_len", want.nbytes, cpl_if.cpl_len);
          check_field("cpl_data", want.data, cpl_if.cpl_data);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        cpl_if.ready <= 1'b0;
      end else begin
        cpl_if.ready <= 1'b1;
        stall_left = pick_pause(cpl_quiet);
      end
    end
  end

  initial begin
    int         r;
    logic [2:0] bar;
    logic [2:0] rd_cmd;
    logic [2:0] wr_cmd;
    logic [11:0] off;
    req_if.valid = 1'b0;
    req_if.command = CMD_CFG_RD;
    req_if.req_id = '0;
    req_if.tag = '0;
    req_if.offset = '0;
    req_if.size = '0;
    req_if.bar_num = '0;
    req_if.write_data = '0;
    cpl_if.ready = 1'b0;

    // identity word, all widths, alignment and out of range reads
    req_plan.push_back('{CMD_CFG_RD, 16'hFFFF, 8'hFF, 12'd0, 4'd4, 3'd0, '1});
    req_plan.push_back('{CMD_CFG_RD, 16'h0000, 8'h00, 12'd0, 4'd0, 3'd7, '0});
    add_request(CMD_CFG_RD, 12'd1, 4'd1, 3'd0, '0);
    add_request(CMD_CFG_RD, 12'd2, 4'd2, 3'd0, '0);
    add_request(CMD_CFG_RD, 12'd3, 4'd3, 3'd0, '0);
    add_request(CMD_CFG_RD, 12'd0, 4'd15, 3'd0, '0);
    add_request(CMD_CFG_RD, 12'd256, 4'd4, 3'd0, '0);
    add_request(CMD_CFG_RD, 12'hFFF, 4'd2, 3'd0, '0);
    // full word, byte and halfword merges, zero and three byte writes
    add_request(CMD_CFG_WR, 12'd4, 4'd4, 3'd0, '1);
    add_request(CMD_CFG_WR, 12'd5, 4'd1, 3'd0, 64'hFFFF_FFFF_FFFF_FF5A);
    add_request(CMD_CFG_WR, 12'd6, 4'd2, 3'd0, 64'hFFFF_FFFF_FFFF_1234);
    add_request(CMD_CFG_RD, 12'd4, 4'd4, 3'd0, '0);
    add_request(CMD_CFG_WR, 12'd252, 4'd0, 3'd0, 64'h1111_2222_CAFE_F00D);
    add_request(CMD_CFG_WR, 12'd8, 4'd3, 3'd0, 64'hA5A5_A5A5_8765_4321);
    add_request(CMD_CFG_WR, 12'hFFC, 4'd4, 3'd0, '1);
    add_request(CMD_CFG_RD, 12'd252, 4'd4, 3'd0, '0);
    // bar window edges, dropped writes, zero and clipped sizes
    add_request(CMD_MMIO_WR, 12'd0, 4'd8, 3'd0, '1);
    add_request(CMD_MEM_WR, 12'd255, 4'd0, 3'd5, 64'h0123_4567_89AB_CDEF);
    add_request(CMD_MEM_WR, 12'd0, 4'd8, 3'd6, '1);
    add_request(CMD_MMIO_WR, 12'd256, 4'd8, 3'd0, '1);
    add_request(CMD_MEM_RD, 12'd0, 4'd8, 3'd0, '0);
    add_request(CMD_MMIO_RD, 12'd255, 4'd15, 3'd5, '0);
    add_request(CMD_MEM_RD, 12'd0, 4'd0, 3'd0, '0);
    add_request(CMD_MEM_RD, 12'd0, 4'd8, 3'd7, '0);
    add_request(CMD_MMIO_RD, 12'hFFF, 4'd8, 3'd0, '0);
    add_request(CMD_RSVD_A, 12'd0, 4'd4, 3'd0, '1);
    add_request(CMD_RSVD_B, 12'd4, 4'd8, 3'd1, '1);
    directed_reqs = req_plan.size();

    // write then read pairs of one entry, lone requests and unknown commands
    while (req_plan.size() < directed_reqs + RANDOM_REQS) begin
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 2))
        0: begin
          wr_cmd = CMD_CFG_WR;
          rd_cmd = CMD_CFG_RD;
          off = pick_cfg_offset();
        end
        1: begin
          wr_cmd = CMD_MMIO_WR;
          rd_cmd = $urandom_range(0, 1) ? CMD_MMIO_RD : CMD_MEM_RD;
          off = pick_bar_offset();
        end
        default: begin
          wr_cmd = CMD_MEM_WR;
          rd_cmd = $urandom_range(0, 1) ? CMD_MEM_RD : CMD_MMIO_RD;
          off = pick_bar_offset();
        end
      endcase
      bar = pick_bar();
      if (r < 40) begin
        add_request(wr_cmd, off, 4'($urandom), bar, {$urandom, $urandom});
        add_request(rd_cmd, off, 4'($urandom), bar, {$urandom, $urandom});
      end else if (r < 95) begin
        add_request($urandom_range(0, 1) ? wr_cmd : rd_cmd, off, 4'($urandom), bar,
                    {$urandom, $urandom});
      end else begin
        add_request($urandom_range(0, 1) ? CMD_RSVD_A : CMD_RSVD_B, 12'($urandom),
                    4'($urandom), 3'($urandom), {$urandom, $urandom});
      end
    end
    planned_reqs = req_plan.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (accepted_reqs != planned_reqs || cpl_expected.size() != 0);
    repeat (8) @(negedge clk);

    $display("%0d requests (%0d directed) over config space and bar windows,", planned_reqs,
             directed_reqs);
    $display("%0d completions checked, %0d mismatches", cpls_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
